// File: rtl/program_stream_demux_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the program stream demultiplexer
// Shared forms for the concurrent checks on the core's ports.
// ----------------------------------------------------------------------------
`ifndef PROGRAM_STREAM_DEMUX_CORE_ASSERT_SVH
`define PROGRAM_STREAM_DEMUX_CORE_ASSERT_SVH

// same-cycle implication
`define PSD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/psd_pkg.sv
// ----------------------------------------------------------------------------
// Program stream demultiplexer package
// Result kinds, start code ids and timestamp unpacking.
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam int TsW = 33;

  localparam logic [1:0] KIND_PAY  = 2'd0;
  localparam logic [1:0] KIND_PACK = 2'd1;
  localparam logic [1:0] KIND_SYS  = 2'd2;
  localparam logic [1:0] KIND_ERR  = 2'd3;

  localparam logic [7:0] ID_PACK     = 8'hBA;
  localparam logic [7:0] ID_SYS      = 8'hBB;
  localparam logic [7:0] ID_PRIV     = 8'hBD;
  localparam logic [7:0] ID_AUDIO_LO = 8'hC0;
  localparam logic [7:0] ID_AUDIO_HI = 8'hC3;
  localparam logic [7:0] ID_VIDEO    = 8'hE0;

  // strip marker bits from a 5-byte timestamp field
  function automatic logic [TsW-1:0] ts_of(input logic [39:0] v);
    return {v[35:33], v[31:17], v[15:1]};
  endfunction

endpackage

// File: rtl/program_stream_demux_core.sv
// ----------------------------------------------------------------------------
// Program stream demultiplexer core
// Byte-serial parser for pack, system and packet headers; emits payload, header and error words.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------
//  in       | in_valid / in_stall    | command, in_byte
//  out      | out_valid / out_stall  | kind, stream_id, data_byte, pts, ...
//  cfg      | cfg_valid / cfg_ready  | cfg_data (video_only)
//
// One byte per cycle sustained while the output is not stalled; a word passes the
// input register, then the parser step into the result register.
// rst is synchronous and clears parser state, valids and video_only to 1.
// An output stall holds the result register; the input register then stalls.
// ----------------------------------------------------------------------------
module program_stream_demux_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    command,
  input  logic [7:0]              in_byte,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              kind,
  output logic [7:0]              stream_id,
  output logic [7:0]              data_byte,
  output logic [psd_pkg::TsW-1:0] pts,
  output logic                    pts_valid,
  output logic                    first_byte,
  output logic                    last_byte,
  output logic [5:0]              audio_streams,
  output logic [4:0]              video_streams,
  output logic [psd_pkg::TsW-1:0] scr,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_data
);
  import psd_pkg::*;

  typedef enum logic [3:0] {
    PH_SCAN, PH_CODE, PH_PACK, PH_SYS, PH_LEN, PH_STUFF,
    PH_STD, PH_MARK, PH_TS, PH_TSD, PH_DTS, PH_PAY
  } phase_t;

  typedef struct packed {
    logic [1:0]     kind;
    logic [7:0]     stream_id;
    logic [7:0]     data_byte;
    logic [TsW-1:0] pts;
    logic           pts_valid;
    logic           first_byte;
    logic           last_byte;
    logic [5:0]     audio_streams;
    logic [4:0]     video_streams;
    logic [TsW-1:0] scr;
  } result_t;

  logic           s0_valid;
  logic           s0_command;
  logic [7:0]     s0_byte;
  logic           advance;

  logic           video_only;
  phase_t         phase, phase_next;
  logic [1:0]     zero_run, zero_run_next;
  logic [3:0]     hcount, hcount_next;
  logic [39:0]    shift, shift_next;
  logic [7:0]     cur_id, cur_id_next;
  logic [15:0]    rem, rem_next;
  logic [TsW-1:0] pts_value, pts_value_next;
  logic           pts_present, pts_present_next;
  logic [1:0]     headers_done, headers_done_next;

  result_t        res, res_next;
  logic           res_fire;

  logic [1:0]     ts_mode;
  logic [3:0]     ts_need;
  logic [15:0]    ts_rem;
  logic [15:0]    pay_rem;
  logic [39:0]    shift_in;

  assign advance   = s0_valid && (!out_valid || !out_stall);
  assign in_stall  = s0_valid && !advance;
  assign cfg_ready = 1'b1;

  assign ts_mode  = s0_byte[5:4];
  assign ts_need  = (ts_mode == 2'd3) ? 4'd10 : (ts_mode == 2'd2) ? 4'd5 : 4'd1;
  assign ts_rem   = rem - {12'd0, ts_need};
  assign pay_rem  = (rem != 16'd0) ? rem - 16'd1 : rem;
  assign shift_in = {shift[31:0], s0_byte};

  always_comb begin
    phase_next        = phase;
    zero_run_next     = zero_run;
    hcount_next       = hcount;
    shift_next        = shift;
    cur_id_next       = cur_id;
    rem_next          = rem;
    pts_value_next    = pts_value;
    pts_present_next  = pts_present;
    headers_done_next = headers_done;
    res_next          = '0;
    res_fire          = 1'b0;

    if (s0_command) begin
      phase_next       = PH_SCAN;
      zero_run_next    = 2'd0;
      hcount_next      = 4'd0;
      rem_next         = 16'd0;
      shift_next       = '0;
      cur_id_next      = 8'd0;
      pts_present_next = 1'b0;
    end else begin
      unique case (phase)
        PH_CODE: begin
          zero_run_next = 2'd0;
          hcount_next   = 4'd0;
          shift_next    = '0;
          if (headers_done == 2'd0 && s0_byte == ID_PACK) begin
            phase_next = PH_PACK;
          end else if (headers_done == 2'd1 && s0_byte == ID_SYS) begin
            phase_next = PH_SYS;
          end else if (headers_done >= 2'd2 && (s0_byte == ID_VIDEO || s0_byte == ID_PRIV ||
                       (s0_byte >= ID_AUDIO_LO && s0_byte <= ID_AUDIO_HI))) begin
            cur_id_next      = s0_byte;
            pts_present_next = 1'b0;
            phase_next       = PH_LEN;
          end else begin
            phase_next = PH_SCAN;
          end
        end
        PH_PACK: begin
          if (hcount == 4'd0 && s0_byte[7:4] != 4'd2) begin
            res_fire           = 1'b1;
            res_next.kind      = KIND_ERR;
            res_next.stream_id = ID_PACK;
            phase_next         = PH_SCAN;
            zero_run_next      = 2'd0;
            hcount_next        = 4'd0;
            rem_next           = 16'd0;
          end else if (hcount == 4'd7) begin
            res_fire           = 1'b1;
            res_next.kind      = KIND_PACK;
            res_next.stream_id = ID_PACK;
            res_next.scr       = ts_of(shift);
            headers_done_next  = 2'd1;
            phase_next         = PH_SCAN;
            zero_run_next      = 2'd0;
            hcount_next        = 4'd0;
            rem_next           = 16'd0;
          end else begin
            if (hcount < 4'd5) begin
              shift_next = shift_in;
            end
            hcount_next = hcount + 4'd1;
          end
        end
        PH_SYS: begin
          shift_next = shift_in;
          if (hcount == 4'd6) begin
            res_fire               = 1'b1;
            res_next.kind          = KIND_SYS;
            res_next.stream_id     = ID_SYS;
            res_next.audio_streams = shift_in[15:10];
            res_next.video_streams = shift_in[4:0];
            headers_done_next      = 2'd2;
            phase_next             = PH_SCAN;
            zero_run_next          = 2'd0;
            hcount_next            = 4'd0;
            rem_next               = 16'd0;
          end else begin
            hcount_next = hcount + 4'd1;
          end
        end
        PH_LEN: begin
          if (hcount == 4'd0) begin
            rem_next    = {s0_byte, 8'd0};
            hcount_next = 4'd1;
          end else begin
            rem_next    = {rem[15:8], s0_byte};
            hcount_next = 4'd0;
            phase_next  = PH_STUFF;
          end
        end
        PH_STUFF, PH_MARK: begin
          priority if (phase == PH_STUFF && s0_byte == 8'hFF) begin
            if (rem == 16'd0) begin
              res_fire           = 1'b1;
              res_next.kind      = KIND_ERR;
              res_next.stream_id = cur_id;
              phase_next         = PH_SCAN;
              zero_run_next      = 2'd0;
              hcount_next        = 4'd0;
              rem_next           = 16'd0;
            end else begin
              rem_next = rem - 16'd1;
            end
          end else if (phase == PH_STUFF && s0_byte[7:6] == 2'b01) begin
            if (rem < 16'd2) begin
              res_fire           = 1'b1;
              res_next.kind      = KIND_ERR;
              res_next.stream_id = cur_id;
              phase_next         = PH_SCAN;
              zero_run_next      = 2'd0;
              hcount_next        = 4'd0;
              rem_next           = 16'd0;
            end else begin
              rem_next   = rem - 16'd2;
              phase_next = PH_STD;
            end
          end else if (ts_mode == 2'd1 || rem < {12'd0, ts_need}) begin
            res_fire           = 1'b1;
            res_next.kind      = KIND_ERR;
            res_next.stream_id = cur_id;
            phase_next         = PH_SCAN;
            zero_run_next      = 2'd0;
            hcount_next        = 4'd0;
            rem_next           = 16'd0;
          end else if (ts_mode == 2'd0) begin
            rem_next    = ts_rem;
            hcount_next = 4'd0;
            if (ts_rem == 16'd0) begin
              phase_next    = PH_SCAN;
              zero_run_next = 2'd0;
            end else begin
              phase_next = PH_PAY;
            end
          end else begin
            rem_next    = ts_rem;
            shift_next  = {32'd0, s0_byte};
            hcount_next = 4'd1;
            phase_next  = (ts_mode == 2'd3) ? PH_TSD : PH_TS;
          end
        end
        PH_STD: begin
          phase_next = PH_MARK;
        end
        PH_TS, PH_TSD: begin
          shift_next = shift_in;
          if (hcount == 4'd4) begin
            pts_value_next   = ts_of(shift_in);
            pts_present_next = 1'b1;
            hcount_next      = 4'd0;
            if (phase == PH_TSD) begin
              phase_next = PH_DTS;
            end else if (rem == 16'd0) begin
              phase_next    = PH_SCAN;
              zero_run_next = 2'd0;
            end else begin
              phase_next = PH_PAY;
            end
          end else begin
            hcount_next = hcount + 4'd1;
          end
        end
        PH_DTS: begin
          if (hcount >= 4'd4) begin
            hcount_next = 4'd0;
            if (rem == 16'd0) begin
              phase_next    = PH_SCAN;
              zero_run_next = 2'd0;
            end else begin
              phase_next = PH_PAY;
            end
          end else begin
            hcount_next = hcount + 4'd1;
          end
        end
        PH_PAY: begin
          hcount_next = 4'd1;
          rem_next    = pay_rem;
          if (pay_rem == 16'd0) begin
            phase_next    = PH_SCAN;
            zero_run_next = 2'd0;
            hcount_next   = 4'd0;
          end
          if (!(video_only && cur_id != ID_VIDEO)) begin
            res_fire            = 1'b1;
            res_next.kind       = KIND_PAY;
            res_next.stream_id  = cur_id;
            res_next.data_byte  = s0_byte;
            res_next.pts        = pts_present ? pts_value : '0;
            res_next.pts_valid  = pts_present;
            res_next.first_byte = (hcount == 4'd0);
            res_next.last_byte  = (pay_rem == 16'd0);
          end
        end
        default: begin
          phase_next = PH_SCAN;
          if (s0_byte == 8'd0) begin
            if (zero_run < 2'd2) begin
              zero_run_next = zero_run + 2'd1;
            end
          end else if (s0_byte == 8'd1 && zero_run >= 2'd2) begin
            zero_run_next = 2'd0;
            phase_next    = PH_CODE;
          end else begin
            zero_run_next = 2'd0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid     <= 1'b0;
      out_valid    <= 1'b0;
      video_only   <= 1'b1;
      phase        <= PH_SCAN;
      zero_run     <= 2'd0;
      hcount       <= 4'd0;
      shift        <= '0;
      cur_id       <= 8'd0;
      rem          <= 16'd0;
      pts_value    <= '0;
      pts_present  <= 1'b0;
      headers_done <= 2'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        video_only <= cfg_data;
      end
      if (in_valid && !in_stall) begin
        s0_valid   <= 1'b1;
        s0_command <= command;
        s0_byte    <= in_byte;
      end else if (advance) begin
        s0_valid <= 1'b0;
      end
      if (advance) begin
        phase        <= phase_next;
        zero_run     <= zero_run_next;
        hcount       <= hcount_next;
        shift        <= shift_next;
        cur_id       <= cur_id_next;
        rem          <= rem_next;
        pts_value    <= pts_value_next;
        pts_present  <= pts_present_next;
        headers_done <= headers_done_next;
        out_valid    <= res_fire;
        if (res_fire) begin
          res <= res_next;
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign kind          = res.kind;
  assign stream_id     = res.stream_id;
  assign data_byte     = res.data_byte;
  assign pts           = res.pts;
  assign pts_valid     = res.pts_valid;
  assign first_byte    = res.first_byte;
  assign last_byte     = res.last_byte;
  assign audio_streams = res.audio_streams;
  assign video_streams = res.video_streams;
  assign scr           = res.scr;

endmodule

// File: rtl/psd_checker.sv
// ----------------------------------------------------------------------------
// Program stream demultiplexer port checker
// Watches the core's output words for consistent field use over time.
// ----------------------------------------------------------------------------
`include "program_stream_demux_core_assert.svh"

module psd_checker (
  input logic                    clk,
  input logic                    rst,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [1:0]              kind,
  input logic [7:0]              stream_id,
  input logic [7:0]              data_byte,
  input logic [psd_pkg::TsW-1:0] pts,
  input logic                    pts_valid,
  input logic                    first_byte,
  input logic                    last_byte,
  input logic [5:0]              audio_streams,
  input logic [4:0]              video_streams,
  input logic [psd_pkg::TsW-1:0] scr
);
  import psd_pkg::*;

  `PSD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
    out_valid && $stable(kind) && $stable(data_byte) && $stable(stream_id),
    "stalled output word changed")

  `PSD_ASSERT_NOW(a_pack_word, clk, rst, out_valid && kind == KIND_PACK,
    stream_id == ID_PACK && !pts_valid && audio_streams == 6'd0 && video_streams == 5'd0,
    "pack header word malformed")

  `PSD_ASSERT_NOW(a_sys_word, clk, rst, out_valid && kind == KIND_SYS,
    stream_id == ID_SYS && scr == '0 && !pts_valid,
    "system header word malformed")

  `PSD_ASSERT_NOW(a_marks, clk, rst, out_valid && kind != KIND_PAY,
    !first_byte && !last_byte && data_byte == 8'd0 && pts == '0,
    "payload fields set outside a payload word")

  `PSD_ASSERT_NOW(a_pts_zero, clk, rst, out_valid && kind == KIND_PAY && !pts_valid,
    pts == '0 && scr == '0,
    "payload word carries a stale timestamp")

endmodule

bind program_stream_demux_core psd_checker u_psd_checker (.*);
